[hw/rtl/bfdh_pkg.sv]
// ---------------------------------------------------------------------------
// bfdh_pkg
// Shared constants, codes and control types of the double-hashing Bloom
// filter.
// ---------------------------------------------------------------------------
package bfdh_pkg;

    localparam int DEFAULT_MAX_BITS = 4096;

    localparam int KEY_W         = 64;
    localparam int HALF_W        = 32;
    localparam int ACTION_W      = 2;
    localparam int FILTER_BITS_W = 13;
    localparam int PROBE_COUNT_W = 8;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_INDEX_W   = 1;
    localparam int ROW_W         = 32;
    localparam int DIV_CW        = $clog2(HALF_W);

    localparam logic [FILTER_BITS_W-1:0] FILTER_BITS_RESET = 13'd4096;
    localparam logic [PROBE_COUNT_W-1:0] PROBE_COUNT_RESET = 8'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_BITS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PROBE_COUNT = 1'b1;

    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic load;
        logic div_step;
        logic probe_init;
        logic rd;
        logic wr;
        logic adv;
        logic clr_init;
        logic clr_wr;
    } dp_cmd_t;

    typedef struct packed {
        logic m_zero;
        logic bit_set;
        logic clr_last;
    } dp_status_t;

endpackage

[hw/rtl/bfdh_dp.sv]
// ---------------------------------------------------------------------------
// bfdh_dp
// Datapath: bit-serial remainder units for both hash halves, probe position
// walker and the row-organized bit store with its clearing counter.
// ---------------------------------------------------------------------------
module bfdh_dp #(
    parameter int MAX_BITS = bfdh_pkg::DEFAULT_MAX_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bfdh_pkg::dp_cmd_t                   cmd,
    input  logic [bfdh_pkg::KEY_W-1:0]          key_hash,
    input  logic [bfdh_pkg::FILTER_BITS_W-1:0]  filter_bits,
    output bfdh_pkg::dp_status_t                status
);
    import bfdh_pkg::*;

    localparam int MW     = $clog2(MAX_BITS + 1);
    localparam int PW     = $clog2(MAX_BITS);
    localparam int OW     = $clog2(ROW_W);
    localparam int PAW    = (PW > OW) ? PW : OW + 1;
    localparam int ROW_AW = PAW - OW;
    localparam int ROWS   = (MAX_BITS + ROW_W - 1) / ROW_W;

    logic [MW-1:0]        m_live;
    logic [MW-1:0]        m_reg;
    logic [HALF_W-1:0]    h1_reg;
    logic [HALF_W-1:0]    h2_reg;
    logic [MW-1:0]        rem1_reg;
    logic [MW-1:0]        rem2_reg;
    logic [MW-1:0]        rem1_next;
    logic [MW-1:0]        rem2_next;
    logic [MW:0]          trial1;
    logic [MW:0]          trial2;
    logic [MW-1:0]        pos_reg;
    logic [MW-1:0]        step_reg;
    logic [MW-1:0]        pos_next;
    logic [MW:0]          pos_sum;
    logic [PAW-1:0]       pos_ext;
    logic [ROW_AW-1:0]    pos_row;
    logic [OW-1:0]        pos_off;
    logic [ROW_W-1:0]     bit_mask;
    logic [ROW_AW-1:0]    clr_row_reg;
    logic [ROW_W-1:0]     rd_data_reg;
    logic                 mem_we;
    logic [ROW_AW-1:0]    mem_waddr;
    logic [ROW_W-1:0]     mem_wdata;
    logic [ROW_W-1:0]     mem [ROWS];

    // The filter size in use saturates at the store size.
    assign m_live = (32'(filter_bits) > 32'(MAX_BITS)) ? MW'(MAX_BITS) : MW'(filter_bits);

    // One restoring remainder step per cycle while div_step is high, most significant dividend bit first.
    assign trial1 = {rem1_reg, h1_reg[HALF_W-1]};
    assign trial2 = {rem2_reg, h2_reg[HALF_W-1]};

    always_comb
    begin
        if (trial1 >= {1'b0, m_reg})
        begin
            rem1_next = MW'(trial1 - {1'b0, m_reg});
        end
        else
        begin
            rem1_next = trial1[MW-1:0];
        end
        if (trial2 >= {1'b0, m_reg})
        begin
            rem2_next = MW'(trial2 - {1'b0, m_reg});
        end
        else
        begin
            rem2_next = trial2[MW-1:0];
        end
    end

    // Position and step are both below m, so one subtraction wraps the sum.
    assign pos_sum = {1'b0, pos_reg} + {1'b0, step_reg};

    always_comb
    begin
        if (pos_sum >= {1'b0, m_reg})
        begin
            pos_next = MW'(pos_sum - {1'b0, m_reg});
        end
        else
        begin
            pos_next = pos_sum[MW-1:0];
        end
    end

    assign pos_ext  = PAW'(pos_reg[PW-1:0]);
    assign pos_row  = pos_ext[PAW-1:OW];
    assign pos_off  = pos_ext[OW-1:0];
    assign bit_mask = {{(ROW_W-1){1'b0}}, 1'b1} << pos_off;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_reg    <= m_live;
            h1_reg   <= key_hash[HALF_W-1:0];
            h2_reg   <= (key_hash[KEY_W-1:HALF_W] == '0) ? HALF_W'(1)
                                                         : key_hash[KEY_W-1:HALF_W];
            rem1_reg <= '0;
            rem2_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            h1_reg   <= h1_reg << 1;
            h2_reg   <= h2_reg << 1;
            rem1_reg <= rem1_next;
            rem2_reg <= rem2_next;
        end
        if (cmd.probe_init)
        begin
            pos_reg  <= rem1_reg;
            step_reg <= rem2_reg;
        end
        else if (cmd.adv)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_row_reg <= '0;
        end
        else if (cmd.clr_init)
        begin
            clr_row_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_row_reg <= clr_row_reg + 1'b1;
        end
    end

    assign mem_we    = cmd.clr_wr | cmd.wr;
    assign mem_waddr = cmd.clr_wr ? clr_row_reg : pos_row;
    assign mem_wdata = cmd.clr_wr ? '0 : (rd_data_reg | bit_mask);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[pos_row];
        end
    end

    assign status.m_zero   = (m_live == '0);
    assign status.bit_set  = rd_data_reg[pos_off];
    assign status.clr_last = (clr_row_reg == ROW_AW'(ROWS - 1));

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> (pos_reg < m_reg))
        else $error("probe position not below filter size");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clr_wr && cmd.wr))
        else $error("clear and set writes collide on the store port");

    a_pos_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |=> $stable(pos_reg))
        else $error("probe position moved between read and check");

endmodule

[hw/rtl/bfdh_ctrl.sv]
// ---------------------------------------------------------------------------
// bfdh_ctrl
// Controller: sequences the clearing pass, the remainder iterations and the
// probe read/check steps, and drives the result strobe.
// ---------------------------------------------------------------------------
module bfdh_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [bfdh_pkg::ACTION_W-1:0]       action,
    input  logic [bfdh_pkg::PROBE_COUNT_W-1:0]  probe_count,
    input  bfdh_pkg::dp_status_t                status,
    output bfdh_pkg::dp_cmd_t                   cmd,
    output logic                                busy,
    output logic                                done,
    output logic                                maybe_present
);
    import bfdh_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_PREP,
        S_RD,
        S_CHK
    } state_t;

    localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(HALF_W - 1);

    state_t                   state_reg;
    state_t                   state_next;
    logic [DIV_CW-1:0]        div_cnt_reg;
    logic [DIV_CW-1:0]        div_cnt_next;
    logic [PROBE_COUNT_W-1:0] probe_cnt_reg;
    logic [PROBE_COUNT_W-1:0] probe_cnt_next;
    logic                     is_query_reg;
    logic                     is_query_next;
    logic                     clr_pending_reg;
    logic                     clr_pending_next;
    logic                     done_reg;
    logic                     done_next;
    logic                     hit_reg;
    logic                     hit_next;

    always_comb
    begin
        state_next       = state_reg;
        div_cnt_next     = div_cnt_reg;
        probe_cnt_next   = probe_cnt_reg;
        is_query_next    = is_query_reg;
        clr_pending_next = clr_pending_reg;
        done_next        = 1'b0;
        hit_next         = 1'b0;
        cmd              = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next       = S_IDLE;
                    done_next        = clr_pending_reg;
                    clr_pending_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (action) inside
                        ACT_ADD, ACT_QUERY:
                        begin
                            is_query_next = (action == ACT_QUERY);
                            if (status.m_zero)
                            begin
                                done_next = 1'b1;
                                hit_next  = (action == ACT_QUERY);
                            end
                            else
                            begin
                                cmd.load     = 1'b1;
                                div_cnt_next = '0;
                                state_next   = S_DIV;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            cmd.clr_init     = 1'b1;
                            clr_pending_next = 1'b1;
                            state_next       = S_CLEAR;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.probe_init = 1'b1;
                probe_cnt_next = '0;
                if (probe_count == '0)
                begin
                    done_next  = 1'b1;
                    hit_next   = is_query_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.wr = !is_query_reg;
                if (is_query_reg && !status.bit_set)
                begin
                    // A query stops at its first clear bit.
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.adv = 1'b1;
                    if (probe_cnt_reg == probe_count - 1'b1)
                    begin
                        done_next  = 1'b1;
                        hit_next   = is_query_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        probe_cnt_next = probe_cnt_reg + 1'b1;
                        state_next     = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The store is swept clean right after reset before any item is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            div_cnt_reg     <= '0;
            probe_cnt_reg   <= '0;
            is_query_reg    <= 1'b0;
            clr_pending_reg <= 1'b0;
            done_reg        <= 1'b0;
            hit_reg         <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            div_cnt_reg     <= div_cnt_next;
            probe_cnt_reg   <= probe_cnt_next;
            is_query_reg    <= is_query_next;
            clr_pending_reg <= clr_pending_next;
            done_reg        <= done_next;
            hit_reg         <= hit_next;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign maybe_present = hit_reg;

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while still working");

    a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg != S_IDLE || done_reg))
        else $error("accepted item neither started nor finished");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_step, cmd.probe_init, cmd.rd, cmd.adv,
                  cmd.clr_init, cmd.clr_wr}))
        else $error("conflicting datapath commands");

    a_hit_only_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> done_reg)
        else $error("hit flag without result strobe");

endmodule

[hw/rtl/bloom_filter_double_hash.sv]
// ---------------------------------------------------------------------------
// bloom_filter_double_hash
// Bloom filter with double hashing over a bit store of MAX_BITS bits. An
// item is taken when start is high and busy is low; its single result
// appears on maybe_present with done high for one cycle, and the receiver
// cannot stall it. An add or query runs the bit-serial reductions of both
// hash halves by m, a setup step for the walk, then a read and a check
// or write-back per probe on the store's single port (a query that meets a
// clear bit ends sooner). With m zero, and for the unused action code, the
// result follows in the next cycle; with k zero the reductions and the
// setup step still run. A clear, and the clearing pass after reset, sweep
// the store one 32-bit row per cycle, with busy high.
// Configuration is written through cfg_we, cfg_index and cfg_data.
// ---------------------------------------------------------------------------
module bloom_filter_double_hash #(
    parameter int MAX_BITS = bfdh_pkg::DEFAULT_MAX_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [bfdh_pkg::ACTION_W-1:0]      action,
    input  logic [bfdh_pkg::KEY_W-1:0]         key_hash,
    output logic                               done,
    output logic                               maybe_present,
    input  logic                               cfg_we,
    input  logic [bfdh_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bfdh_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bfdh_pkg::*;

    logic [FILTER_BITS_W-1:0] filter_bits_reg;
    logic [PROBE_COUNT_W-1:0] probe_count_reg;
    dp_cmd_t                  cmd;
    dp_status_t               status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_bits_reg <= FILTER_BITS_RESET;
            probe_count_reg <= PROBE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FILTER_BITS: filter_bits_reg <= cfg_data[FILTER_BITS_W-1:0];
                REG_PROBE_COUNT: probe_count_reg <= cfg_data[PROBE_COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    bfdh_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .action        (action),
        .probe_count   (probe_count_reg),
        .status        (status),
        .cmd           (cmd),
        .busy          (busy),
        .done          (done),
        .maybe_present (maybe_present)
    );

    bfdh_dp #(
        .MAX_BITS (MAX_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .key_hash    (key_hash),
        .filter_bits (filter_bits_reg),
        .status      (status)
    );

endmodule

[verif/bloom_filter_double_hash_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bloom_filter_double_hash_checker
// Watches the item, result and register ports of the Bloom filter, keeps its
// own copy of the bit store and of the two registers, works out the hit flag
// of every accepted item and compares each result transfer with the oldest
// outstanding prediction.
// ---------------------------------------------------------------------------
module bloom_filter_double_hash_checker #(
    parameter int MAX_BITS = bfdh_pkg::DEFAULT_MAX_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic [bfdh_pkg::ACTION_W-1:0]      action,
    input  logic [bfdh_pkg::KEY_W-1:0]         key_hash,
    input  logic                               done,
    input  logic                               maybe_present,
    input  logic                               cfg_we,
    input  logic [bfdh_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bfdh_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                 pending,
    output int                                 mismatches
);

    import bfdh_pkg::*;

    logic                     filter_store [MAX_BITS];
    logic [FILTER_BITS_W-1:0] size_reg;
    logic [PROBE_COUNT_W-1:0] probes_reg;
    logic                     hit_q [$];
    int                       item_count;
    int                       result_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic void clear_store();
        int j;
        for (j = 0; j < MAX_BITS; j++)
            filter_store[j] = 1'b0;
    endfunction

    // Walks the k probe positions, setting them for an add and testing them
    // for a query. The position wraps by one subtraction of m per step.
    function automatic logic walk_probes(input logic [KEY_W-1:0] key, input logic adding);
        logic [31:0] m;
        logic [31:0] h1;
        logic [31:0] h2;
        logic [31:0] pos;
        logic [31:0] step;
        int          i;
        m = (size_reg > MAX_BITS) ? 32'(MAX_BITS) : 32'(size_reg);
        if (m == 0)
            return 1'b1;
        h1 = key[HALF_W-1:0];
        h2 = key[KEY_W-1:HALF_W];
        if (h2 == 0)
            h2 = 32'd1;
        pos  = h1 % m;
        step = h2 % m;
        for (i = 0; i < probes_reg; i++)
        begin
            if (adding)
                filter_store[pos] = 1'b1;
            else if (!filter_store[pos])
                return 1'b0;
            pos = pos + step;
            if (pos >= m)
                pos = pos - m;
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic want_hit;
        logic new_hit;
        if (!rst_n)
        begin
            clear_store();
            size_reg     = FILTER_BITS_RESET;
            probes_reg   = PROBE_COUNT_RESET;
            hit_q.delete();
            item_count   = 0;
            result_count = 0;
            mismatches   = 0;
            pending     <= 0;
        end
        else
        begin
            // A result at this edge always belongs to an earlier item.
            if (done)
            begin
                if (hit_q.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with no item outstanding",
                                              result_count));
                else
                begin
                    want_hit = hit_q.pop_front();
                    if (maybe_present !== want_hit)
                        report_mismatch($sformatf("result %0d: maybe_present %b, predicted %b",
                                                  result_count, maybe_present, want_hit));
                end
                result_count++;
            end
            if (start && !busy)
            begin
                new_hit = 1'b0;
                case (action)
                    ACT_ADD:   void'(walk_probes(key_hash, 1'b1));
                    ACT_QUERY: new_hit = walk_probes(key_hash, 1'b0);
                    ACT_CLEAR: clear_store();
                    default:   new_hit = 1'b0;
                endcase
                hit_q.push_back(new_hit);
                item_count++;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FILTER_BITS: size_reg   = cfg_data[FILTER_BITS_W-1:0];
                    REG_PROBE_COUNT: probes_reg = cfg_data[PROBE_COUNT_W-1:0];
                    default:         ;
                endcase
            end
            pending <= hit_q.size();
        end
    end

endmodule

[verif/bloom_filter_double_hash_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bloom_filter_double_hash_test
// Drives adds, queries and clears into the Bloom filter under a range of
// filter sizes and probe counts, with random gaps between transfers. The
// checker beside the block predicts and compares every result; this module
// makes the stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module bloom_filter_double_hash_test;

    import bfdh_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 600;
    localparam int KEY_HISTORY    = 64;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [ACTION_W-1:0]      action = ACT_ADD;
    logic [KEY_W-1:0]         key_hash = '0;
    logic                     done;
    logic                     maybe_present;
    logic                     cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index = REG_FILTER_BITS;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    int                       pending;
    int                       mismatches;
    int                       idle_cycles = 0;
    int                       burst_left = 0;
    logic [KEY_W-1:0]         added_keys [$];

    bloom_filter_double_hash dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .key_hash      (key_hash),
        .done          (done),
        .maybe_present (maybe_present),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    bloom_filter_double_hash_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .key_hash      (key_hash),
        .done          (done),
        .maybe_present (maybe_present),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .mismatches    (mismatches)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Any transfer on any port restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] key);
        start    <= 1'b1;
        action   <= act;
        key_hash <= key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
    endtask

    task automatic set_config(input int m, input int k);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_FILTER_BITS;
        cfg_data  <= CFG_DATA_W'(m);
        @(posedge clk);
        cfg_index <= REG_PROBE_COUNT;
        cfg_data  <= CFG_DATA_W'(k);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return {32'h0, 32'($urandom)};
            1:       return {32'($urandom), 32'hFFFF_FFFF};
            2:       return '1;
            3:       return {32'($urandom), 32'h0};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic int random_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
            burst_left = $urandom_range(10, 40);
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly adds of fresh keys and queries of keys added lately, with
    // unseen keys, clears and the unused code mixed in.
    task automatic run_phase(input int m, input int k, input int count);
        int               n;
        int               r;
        logic [ACTION_W-1:0] act;
        logic [KEY_W-1:0] key;
        set_config(m, k);
        for (n = 0; n < count; n++)
        begin
            r   = $urandom_range(0, 99);
            key = random_key();
            if (r < 3)
                act = ACT_CLEAR;
            else if (r < 6)
                act = ACT_UNUSED;
            else if (r < 50)
                act = ACT_ADD;
            else
            begin
                act = ACT_QUERY;
                if (added_keys.size() > 0 && $urandom_range(0, 9) < 6)
                    key = added_keys[$urandom_range(0, added_keys.size() - 1)];
            end
            send_item(act, key);
            if (act == ACT_ADD)
            begin
                added_keys.push_back(key);
                if (added_keys.size() > KEY_HISTORY)
                    void'(added_keys.pop_front());
            end
            idle_sender(random_gap());
            if ($urandom_range(0, 199) == 0)
                drain();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: empty store, hits after adds, zero and all-ones keys.
        send_item(ACT_QUERY, 64'h0123_4567_89AB_CDEF);
        send_item(ACT_ADD,   64'h0123_4567_89AB_CDEF);
        send_item(ACT_QUERY, 64'h0123_4567_89AB_CDEF);
        send_item(ACT_ADD,   64'h0000_0000_FFFF_FFFF);
        send_item(ACT_QUERY, 64'h0000_0000_FFFF_FFFF);
        send_item(ACT_ADD,   64'hFFFF_FFFF_FFFF_FFFF);
        send_item(ACT_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(ACT_QUERY, 64'h0);
        send_item(ACT_ADD,   64'h0);
        send_item(ACT_QUERY, 64'h0);
        send_item(ACT_UNUSED, 64'h0123_4567_89AB_CDEF);
        send_item(ACT_CLEAR, 64'h0);
        send_item(ACT_QUERY, 64'h0123_4567_89AB_CDEF);

        // A zero-size filter answers every query with a hit.
        set_config(0, 3);
        send_item(ACT_ADD,   64'hDEAD_BEEF_0000_1111);
        send_item(ACT_QUERY, 64'hDEAD_BEEF_0000_1111);
        // With no probes nothing can fail.
        set_config(4096, 0);
        send_item(ACT_QUERY, 64'h1234_0000_5678_0000);
        send_item(ACT_ADD,   64'h1234_0000_5678_0000);
        // Sizes above the store saturate.
        set_config(8191, 2);
        send_item(ACT_ADD,   64'h0123_4567_89AB_CDEF);
        send_item(ACT_QUERY, 64'h0123_4567_89AB_CDEF);
        set_config(1, 255);
        send_item(ACT_ADD,   64'hAAAA_AAAA_AAAA_AAAA);
        send_item(ACT_QUERY, 64'h5555_5555_5555_5555);

        run_phase(4096, 3, 180);
        run_phase(8, 2, 250);
        run_phase(64, 4, 250);
        run_phase(1, 1, 100);
        run_phase(0, 3, 60);
        run_phase(8191, 6, 200);
        run_phase(4097, 2, 60);
        run_phase(300, 0, 60);
        run_phase(1000, 1, 150);
        run_phase(16, 255, 20);
        run_phase(4096, 255, 10);
        run_phase(8, 8, 150);
        run_phase($urandom_range(2, 4096), $urandom_range(1, 10), 150);
        run_phase($urandom_range(2, 200), $urandom_range(1, 10), 150);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/bfdh_pkg.sv
hw/rtl/bfdh_dp.sv
hw/rtl/bfdh_ctrl.sv
hw/rtl/bloom_filter_double_hash.sv
verif/bloom_filter_double_hash_checker.sv
verif/bloom_filter_double_hash_test.sv
